>>> design/slfpr_pkg.sv
// Shared constants, types and the command prefix table for the serial line framer.
`default_nettype none

package slfpr_pkg;

    localparam int BUF_LEN_DEF   = 32;
    localparam int ROW_CHARS_DEF = 16;
    localparam int PFX_LEN       = 5;

    localparam logic [7:0] CHR_CR = 8'd13;
    localparam logic [7:0] CHR_LF = 8'd10;

    // controller -> datapath
    typedef struct packed {
        logic take;        // input item accepted
        logic rd;          // read store at run index, advance index
        logic load;        // load output register from read data
        logic load_empty;  // load output register with the empty-run marker
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic flush;       // current input item ends a line or fills a row
        logic empty;       // captured run has no characters
        logic done;        // run index has reached the run end
    } t_dp_sts;

    function automatic logic [7:0] pfx_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h4F;  // O
            3'd1:    c = 8'h4C;  // L
            3'd2:    c = 8'h45;  // E
            3'd3:    c = 8'h44;  // D
            3'd4:    c = 8'h3A;  // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/slfpr_ctrl.sv
// Controller state machine: input acceptance and line readout sequencing.
`default_nettype none

module slfpr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire slfpr_pkg::t_dp_sts i_sts,
    output slfpr_pkg::t_dp_cmd      o_cmd
);
    import slfpr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_RD    = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.take       = i_in_valid && (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.flush) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.empty) begin
                    o_cmd.load_empty = 1'b1;
                    n_state          = S_OUT;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_RD;
                end
            end
            S_RD: begin
                o_cmd.load = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_sts.done) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd = 1'b1;
                        n_state  = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/slfpr_dpath.sv
// Datapath: line store, fill count, prefix tracking, run readout and output register.
`default_nettype none

module slfpr_dpath #(
    parameter int BUF_LEN   = slfpr_pkg::BUF_LEN_DEF,
    parameter int ROW_CHARS = slfpr_pkg::ROW_CHARS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [7:0]         i_rx_byte,
    input  wire slfpr_pkg::t_dp_cmd i_cmd,
    output slfpr_pkg::t_dp_sts      o_sts,
    output logic [7:0]              o_text_byte,
    output logic                    o_to_command,
    output logic                    o_empty_line,
    output logic                    o_last
);
    import slfpr_pkg::*;

    localparam int AW = $clog2(BUF_LEN);
    localparam int CW = $clog2(BUF_LEN + 1);

    logic [7:0]    r_mem [BUF_LEN];
    logic [CW-1:0] r_fill;
    logic          r_pfx_ok;
    logic [CW-1:0] r_rd_idx;
    logic [CW-1:0] r_end;
    logic          r_cmd;
    logic [7:0]    r_rd_data;
    logic [7:0]    r_out_byte;
    logic          r_out_empty;
    logic          r_out_last;

    logic          is_lf;
    logic          is_chr;
    logic          can_store;
    logic [CW-1:0] n_fill;
    logic          n_pfx_ok;
    logic          has_pfx_now;
    logic          has_pfx_nx;
    logic          row_full;

    assign is_lf     = (i_rx_byte == CHR_LF);
    assign is_chr    = (i_rx_byte != CHR_LF) && (i_rx_byte != CHR_CR);
    assign can_store = (32'(r_fill) < BUF_LEN);
    assign n_fill    = can_store ? r_fill + CW'(1) : r_fill;

    // prefix flag drops on the first mismatch within the first five characters
    always_comb begin
        n_pfx_ok = r_pfx_ok;
        if (can_store && (32'(r_fill) < PFX_LEN)) begin
            n_pfx_ok = r_pfx_ok && (i_rx_byte == pfx_char(r_fill[2:0]));
        end
    end

    assign has_pfx_now = (32'(r_fill) >= PFX_LEN) && r_pfx_ok;
    assign has_pfx_nx  = (32'(n_fill) >= PFX_LEN) && n_pfx_ok;
    assign row_full    = is_chr && (32'(n_fill) >= ROW_CHARS) && !has_pfx_nx;

    assign o_sts.flush = is_lf || row_full;
    assign o_sts.empty = (r_rd_idx >= r_end);
    assign o_sts.done  = (r_rd_idx == r_end);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && is_chr && can_store) begin
            r_mem[r_fill[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_pfx_ok <= 1'b1;
        end else if (i_cmd.take) begin
            if (is_lf || row_full) begin
                r_fill   <= '0;
                r_pfx_ok <= 1'b1;
            end else if (is_chr) begin
                r_fill   <= n_fill;
                r_pfx_ok <= n_pfx_ok;
            end
        end
    end

    // run capture and readout index
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && is_lf) begin
            r_cmd    <= has_pfx_now;
            r_rd_idx <= has_pfx_now ? CW'(PFX_LEN) : '0;
            r_end    <= r_fill;
        end else if (i_cmd.take && row_full) begin
            r_cmd    <= 1'b0;
            r_rd_idx <= '0;
            r_end    <= n_fill;
        end else if (i_cmd.rd) begin
            r_rd_idx <= r_rd_idx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_byte  <= r_rd_data;
            r_out_empty <= 1'b0;
            r_out_last  <= (r_rd_idx == r_end);
        end else if (i_cmd.load_empty) begin
            r_out_byte  <= 8'h00;
            r_out_empty <= 1'b1;
            r_out_last  <= 1'b1;
        end
    end

    assign o_text_byte  = r_out_byte;
    assign o_to_command = r_cmd;
    assign o_empty_line = r_out_empty;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

>>> design/serial_line_framer_prefix_router_top.sv
// Top level of the serial line framer and command prefix router.
//
//  channel | dir | handshake                     | payload
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata[7:0] rx_byte
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tdata[7:0] text_byte,
//          |     |                               | tuser[0] to_command, tuser[1] empty_line,
//          |     |                               | tlast last
//
// A byte that emits nothing is simply accepted. A byte that ends a line or fills a
// row starts a run: a start state, then per character a registered store read plus
// an output register load; an empty run goes from the start state straight to the
// output register with the empty-run marker.
// Input is held off while a run is read out. Output stalls hold the readout.
// Synchronous active-low reset zeroes the fill count; store entries are only read
// below it, so no clearing pass is needed.
`default_nettype none

module serial_line_framer_prefix_router_top #(
    parameter int BUF_LEN   = slfpr_pkg::BUF_LEN_DEF,
    parameter int ROW_CHARS = slfpr_pkg::ROW_CHARS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] text_byte
    output logic [1:0]      m_axis_tuser,   // [0] to_command, [1] empty_line
    output logic            m_axis_tlast
);
    import slfpr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    to_command;
    logic    empty_line;

    slfpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    slfpr_dpath #(
        .BUF_LEN   (BUF_LEN),
        .ROW_CHARS (ROW_CHARS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_byte    (s_axis_tdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_text_byte  (m_axis_tdata),
        .o_to_command (to_command),
        .o_empty_line (empty_line),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tuser = {empty_line, to_command};

    // one line at a time: no input taken while a result is shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while output valid");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && (m_axis_tdata == 8'h00)))
        else $error("empty marker not a single zero item");

    a_cr_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tdata == CHR_CR)) |=> s_axis_tready)
        else $error("carriage return started a run");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("run did not end after last item");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the serial line framer and command prefix router.
`timescale 1ns / 100ps

module tb;
    import slfpr_pkg::*;

    localparam int TB_BUF_LEN   = BUF_LEN_DEF;
    localparam int TB_ROW_CHARS = ROW_CHARS_DEF;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 45;

    // "OLED:" with the first character in the top byte
    localparam logic [39:0] CMD_TAG = "OLED:";

    typedef struct packed {
        logic [7:0] ch;
        logic       cmd;
        logic       empty;
        logic       last;
    } t_row_item;

    // Line store model plus the queue of rows and payload characters still owed.
    class line_router_sb;
        logic [7:0]  line_buf [TB_BUF_LEN];
        int unsigned fill;
        t_row_item   want_q [$];
        int          errors;
        int          shown;

        function new();
            fill   = 0;
            errors = 0;
            shown  = 0;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function bit is_command();
            if (fill < PFX_LEN)
                return 1'b0;
            for (int k = 0; k < PFX_LEN; k++)
                if (line_buf[k] != CMD_TAG[8*(PFX_LEN-1-k) +: 8])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void queue_run(int unsigned from, logic to_cmd);
            t_row_item r;
            if (from >= fill) begin
                r = '{ch: 8'h00, cmd: to_cmd, empty: 1'b1, last: 1'b1};
                want_q.push_back(r);
            end else begin
                for (int unsigned i = from; i < fill; i++) begin
                    r.ch    = line_buf[i];
                    r.cmd   = to_cmd;
                    r.empty = 1'b0;
                    r.last  = (i + 1 == fill);
                    want_q.push_back(r);
                end
            end
        endfunction

        function void note_byte(logic [7:0] b);
            if (b == CHR_CR)
                return;
            if (b == CHR_LF) begin
                if (is_command())
                    queue_run(PFX_LEN, 1'b1);
                else
                    queue_run(0, 1'b0);
                fill = 0;
                return;
            end
            if (fill < TB_BUF_LEN) begin
                line_buf[fill] = b;
                fill++;
            end
            // plain text gets flushed once a full row is held
            if (fill >= TB_ROW_CHARS && !is_command()) begin
                queue_run(0, 1'b0);
                fill = 0;
            end
        endfunction

        task report(string what);
            errors++;
            if (shown < 100) begin
                shown++;
                $display("ERROR at %0t: %s", $time, what);
            end
        endtask

        task check_result(logic [7:0] ch, logic [1:0] user, logic last);
            t_row_item w;
            if (want_q.size() == 0) begin
                report($sformatf("result with nothing owed: byte %02h user %b last %b",
                                 ch, user, last));
                return;
            end
            w = want_q.pop_front();
            if (ch !== w.ch)
                report($sformatf("text_byte %02h, want %02h", ch, w.ch));
            if (user[0] !== w.cmd)
                report($sformatf("to_command %b, want %b", user[0], w.cmd));
            if (user[1] !== w.empty)
                report($sformatf("empty_line %b, want %b", user[1], w.empty));
            if (last !== w.last)
                report($sformatf("last %b, want %b", last, w.last));
        endtask
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] text_byte
    logic [1:0] m_axis_tuser;            // [0] to_command, [1] empty_line
    logic       m_axis_tlast;

    line_router_sb sb;
    int cycles     = 0;
    int send_idle  = 0;
    int recv_stall = 0;
    int sent       = 0;
    logic hold_go    = 1'b0;
    logic hold_armed = 1'b0;
    int   hold_left  = 0;

    serial_line_framer_prefix_router_top #(
        .BUF_LEN   (TB_BUF_LEN),
        .ROW_CHARS (TB_ROW_CHARS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output side: check, then pick tready for the next edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (hold_go && !hold_armed) begin
                hold_armed    <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
            end
        end
    end

    task send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        sb.note_byte(b);
        if (b != CHR_CR)
            sent++;
    endtask

    // Drop valid and hold until every owed result has come out.
    task pause_sender();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    task send_tag(input int n);
        for (int k = 0; k < n; k++)
            send_byte(CMD_TAG[8*(PFX_LEN-1-k) +: 8]);
    endtask

    function automatic logic [7:0] line_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CHR_LF)
            c = 8'h20;
        if ($urandom_range(0, 19) == 0)
            c = CHR_CR;
        return c;
    endfunction

    task send_random_line();
        int         kind;
        int         n;
        int         k;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            // command payload, sometimes long enough to overflow the store
            send_tag(PFX_LEN);
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 12);
            repeat (n) send_byte(line_char());
            send_byte(CHR_LF);
        end else if (kind < 70) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 24) : $urandom_range(0, 15);
            repeat (n) send_byte(line_char());
            send_byte(CHR_LF);
        end else if (kind < 85) begin
            // prefix broken after k characters
            k = $urandom_range(1, 4);
            send_tag(k);
            c = line_char();
            if (c == CMD_TAG[8*(PFX_LEN-1-k) +: 8])
                c = c ^ 8'h01;
            send_byte(c);
            repeat ($urandom_range(0, 6)) send_byte(line_char());
            send_byte(CHR_LF);
        end else begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int target;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty line, ignored CR, empty payload, payload with zero and 0xff,
        // four-character near-prefix, short line
        send_byte(CHR_LF);
        send_byte(CHR_CR);
        send_tag(PFX_LEN);
        send_byte(CHR_LF);
        send_tag(PFX_LEN);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHR_CR);
        send_byte(CHR_LF);
        send_tag(4);
        send_byte(CHR_LF);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(CHR_LF);

        for (int p = 0; p < 4; p++) begin
            pause_sender();
            case (p)
                0: begin send_idle = 0;  recv_stall <= 0;  end
                1: begin send_idle = 82; recv_stall <= 0;  end
                2: begin send_idle = 0;  recv_stall <= 82; end
                default: begin send_idle = 26; recv_stall <= 26; end
            endcase
            target = sent + PHASE_ITEMS;
            while (sent < target)
                send_random_line();
        end

        // long receiver hold with the sender pushing two full rows and a tail
        pause_sender();
        send_idle = 0;
        recv_stall <= 0;
        hold_go <= 1'b1;
        repeat (40) send_byte(8'($urandom_range(14, 255)));
        send_byte(CHR_LF);

        pause_sender();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
